// ----- rtl/dbsp_pkg.sv -----
// Shared types and constants for the debounced button settings panel.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package dbsp_pkg;

	// Button lanes, in the order their effects are applied.
	localparam int NUM_BUTTONS     = 5;
	localparam int BTN_FREQ_UP     = 0;
	localparam int BTN_FREQ_DOWN   = 1;
	localparam int BTN_AMP_UP      = 2;
	localparam int BTN_AMP_DOWN    = 3;
	localparam int BTN_WAVE_NEXT   = 4;

	// The working frequency carries one guard bit above Q24.8 until the clamp.
	localparam int FREQ_W          = 32;
	localparam int FREQ_WORK_W     = FREQ_W + 1;
	localparam int FACTOR_W        = 17;
	localparam int FRAC_BITS       = 16;

	// Configuration port geometry.
	localparam int CFG_ADDR_W      = 5;
	localparam int CFG_DATA_W      = 32;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_SETTLE_MS     = 3'd0;
	localparam logic [2:0] REG_AMP_STEP      = 3'd1;
	localparam logic [2:0] REG_UP_FACTOR     = 3'd2;
	localparam logic [2:0] REG_DOWN_FACTOR   = 3'd3;
	localparam logic [2:0] REG_FREQ_MIN      = 3'd4;
	localparam logic [2:0] REG_FREQ_MAX      = 3'd5;

	// Reset values of registers and settings.
	localparam logic [15:0]          RST_SETTLE_MS   = 16'd25;
	localparam logic [7:0]           RST_AMP_STEP    = 8'd32;
	localparam logic [16:0]          RST_UP_FACTOR   = 17'd72090;
	localparam logic [15:0]          RST_DOWN_FACTOR = 16'd58982;
	localparam logic [FREQ_W-1:0]    RST_FREQ_MIN    = 32'd256;
	localparam logic [FREQ_W-1:0]    RST_FREQ_MAX    = 32'd2560000000;
	localparam logic [FREQ_WORK_W-1:0] RST_FREQ      = 33'd256000;
	localparam logic [7:0]           RST_AMPLITUDE   = 8'd128;
	localparam logic [7:0]           AMP_MAX         = 8'd255;

	// One input request: time stamp and raw active-low button levels.
	typedef struct packed {
		logic [31:0] now_ms;
		logic        freq_up_level;
		logic        freq_down_level;
		logic        amp_up_level;
		logic        amp_down_level;
		logic        wave_next_level;
	} in_req_t;

	// One result: settings after the request and a press indication.
	typedef struct packed {
		logic [31:0] freq_q8;
		logic [7:0]  amplitude;
		logic [1:0]  waveform;
		logic        changed;
	} out_rsp_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UP,
		ST_DOWN,
		ST_CLAMP
	} state_t;

	// Operations of the shared frequency unit.
	typedef enum logic [1:0] {
		FOP_HOLD,
		FOP_UP,
		FOP_DOWN,
		FOP_CLAMP
	} freq_op_t;

endpackage

// ----- rtl/dbsp_debounce.sv -----
// Five-lane button debouncer with press-edge detection.
// Depends on dbsp_pkg for the lane count.
`timescale 1ns / 1ps

module dbsp_debounce #(
	parameter int TIME_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               scan,
	input  logic [TIME_BITS-1:0]               now,
	input  logic [dbsp_pkg::NUM_BUTTONS-1:0]   raw,
	input  logic [15:0]                        settle_ms,
	output logic [dbsp_pkg::NUM_BUTTONS-1:0]   press
);
	import dbsp_pkg::*;

	logic [NUM_BUTTONS-1:0] stable_q;
	logic [NUM_BUTTONS-1:0] last_raw_q;
	logic [TIME_BITS-1:0]   last_time_q [NUM_BUTTONS];

	logic [NUM_BUTTONS-1:0] raw_moved;
	logic [NUM_BUTTONS-1:0] take;
	logic [TIME_BITS-1:0]   since      [NUM_BUTTONS];
	logic [TIME_BITS-1:0]   hold_time;

	assign hold_time = TIME_BITS'(settle_ms);

	// Each lane: restart its timer on a raw change, accept a level that has held long enough.
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			raw_moved[i] = raw[i] != last_raw_q[i];
			since[i]     = raw_moved[i] ? '0 : (now - last_time_q[i]);
			take[i]      = (since[i] >= hold_time) && (stable_q[i] != raw[i]);
			press[i]     = take[i] && stable_q[i] && !raw[i];
		end
	end

	// Lane state advances only when a request is scanned.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q   <= '1;
			last_raw_q <= '1;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				last_time_q[i] <= '0;
			end
		end else if (scan) begin
			last_raw_q <= raw;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (raw_moved[i]) begin
					last_time_q[i] <= now;
				end
				if (take[i]) begin
					stable_q[i] <= raw[i];
				end
			end
		end
	end

endmodule

// ----- rtl/dbsp_freq.sv -----
// Frequency unit: the working frequency register, one shared multiplier for
// both step factors, and the min/max clamp. Depends on dbsp_pkg.
`timescale 1ns / 1ps

module dbsp_freq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dbsp_pkg::freq_op_t             op,
	input  logic [16:0]                    up_factor,
	input  logic [15:0]                    down_factor,
	input  logic [dbsp_pkg::FREQ_W-1:0]    freq_min,
	input  logic [dbsp_pkg::FREQ_W-1:0]    freq_max,
	output logic [dbsp_pkg::FREQ_W-1:0]    clamped
);
	import dbsp_pkg::*;

	logic [FREQ_WORK_W-1:0]          freq_q;
	logic [FACTOR_W-1:0]             factor;
	logic [FREQ_WORK_W+FACTOR_W-1:0] product;
	logic [FREQ_WORK_W-1:0]          scaled;
	logic [FREQ_WORK_W-1:0]          raised;

	// Shared multiplier; the down factor is zero-extended into the same operand.
	assign factor  = (op == FOP_UP) ? up_factor : {1'b0, down_factor};
	assign product = FREQ_WORK_W'(freq_q) * factor;
	assign scaled  = product[FRAC_BITS +: FREQ_WORK_W];

	// Raise to the minimum first, then lower to the maximum.
	assign raised  = (freq_q < {1'b0, freq_min}) ? {1'b0, freq_min} : freq_q;
	assign clamped = (raised > {1'b0, freq_max}) ? freq_max : raised[FREQ_W-1:0];

	// Working register: one product or the clamped value per cycle, as op selects; it holds on FOP_HOLD.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= RST_FREQ;
		end else begin
			case (op)
				FOP_UP, FOP_DOWN: freq_q <= scaled;
				FOP_CLAMP:        freq_q <= {1'b0, clamped};
				default:          freq_q <= freq_q;
			endcase
		end
	end

endmodule

// ----- rtl/debounced_button_settings_panel.sv -----
// Debounced button settings panel: each accepted request passes through the
// sequencer states in order. In the idle state, where a request is accepted,
// all five buttons are debounced and amplitude and waveform presses applied;
// the up and down states are slots of the shared 33x17 frequency multiplier
// (up factor, then down factor); the clamp state clamps the frequency and
// loads the result into the output register. The clamp state waits while the
// previous result is still held under stall, and no new request is taken
// until the result has been loaded: the input stalls from acceptance until then.
// Depends on dbsp_pkg, dbsp_debounce and dbsp_freq.
`timescale 1ns / 1ps

module debounced_button_settings_panel #(
	parameter int TIME_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  dbsp_pkg::in_req_t                  in_req,
	output logic                               out_valid,
	input  logic                               out_stall,
	output dbsp_pkg::out_rsp_t                 out_rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dbsp_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [dbsp_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [dbsp_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                               pready
);
	import dbsp_pkg::*;

	// Configuration registers.
	logic [15:0]        settle_ms_q;
	logic [7:0]         amp_step_q;
	logic [16:0]        up_factor_q;
	logic [15:0]        down_factor_q;
	logic [FREQ_W-1:0]  freq_min_q;
	logic [FREQ_W-1:0]  freq_max_q;

	logic [2:0]         reg_index;
	logic               cfg_write;

	// Sequencer and settings.
	state_t             state_q, state_d;
	freq_op_t           fop;
	logic               accept;
	logic               out_load;
	logic [1:0]         freq_press_q;
	logic               changed_q;
	logic [7:0]         amp_q;
	logic [1:0]         wave_q;

	logic [NUM_BUTTONS-1:0] raw;
	logic [NUM_BUTTONS-1:0] press;
	logic [8:0]             amp_sum;
	logic [7:0]             amp_after_up;
	logic [7:0]             amp_after_down;
	logic [FREQ_W-1:0]      freq_clamped;

	logic               out_valid_q;
	out_rsp_t           out_rsp_q;

	// Configuration port: always ready, writes on the access phase.
	assign pready    = 1'b1;
	assign reg_index = paddr[4:2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ms_q   <= RST_SETTLE_MS;
			amp_step_q    <= RST_AMP_STEP;
			up_factor_q   <= RST_UP_FACTOR;
			down_factor_q <= RST_DOWN_FACTOR;
			freq_min_q    <= RST_FREQ_MIN;
			freq_max_q    <= RST_FREQ_MAX;
		end else if (cfg_write) begin
			case (reg_index)
				REG_SETTLE_MS:   settle_ms_q   <= pwdata[15:0];
				REG_AMP_STEP:    amp_step_q    <= pwdata[7:0];
				REG_UP_FACTOR:   up_factor_q   <= pwdata[16:0];
				REG_DOWN_FACTOR: down_factor_q <= pwdata[15:0];
				REG_FREQ_MIN:    freq_min_q    <= pwdata;
				REG_FREQ_MAX:    freq_max_q    <= pwdata;
				default:         ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_index)
			REG_SETTLE_MS:   prdata = CFG_DATA_W'(settle_ms_q);
			REG_AMP_STEP:    prdata = CFG_DATA_W'(amp_step_q);
			REG_UP_FACTOR:   prdata = CFG_DATA_W'(up_factor_q);
			REG_DOWN_FACTOR: prdata = CFG_DATA_W'(down_factor_q);
			REG_FREQ_MIN:    prdata = freq_min_q;
			REG_FREQ_MAX:    prdata = freq_max_q;
			default:         prdata = '0;
		endcase
	end

	// Button lanes in application order.
	always_comb begin
		raw                = '1;
		raw[BTN_FREQ_UP]   = in_req.freq_up_level;
		raw[BTN_FREQ_DOWN] = in_req.freq_down_level;
		raw[BTN_AMP_UP]    = in_req.amp_up_level;
		raw[BTN_AMP_DOWN]  = in_req.amp_down_level;
		raw[BTN_WAVE_NEXT] = in_req.wave_next_level;
	end

	dbsp_debounce #(
		.TIME_BITS (TIME_BITS)
	) u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.scan        (accept),
		.now         (in_req.now_ms[TIME_BITS-1:0]),
		.raw         (raw),
		.settle_ms   (settle_ms_q),
		.press       (press)
	);

	dbsp_freq u_freq (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (fop),
		.up_factor   (up_factor_q),
		.down_factor (down_factor_q),
		.freq_min    (freq_min_q),
		.freq_max    (freq_max_q),
		.clamped     (freq_clamped)
	);

	// Saturating amplitude steps, up before down.
	assign amp_sum        = {1'b0, amp_q} + {1'b0, amp_step_q};
	assign amp_after_up   = !press[BTN_AMP_UP] ? amp_q :
	                        (amp_sum[8] ? AMP_MAX : amp_sum[7:0]);
	assign amp_after_down = !press[BTN_AMP_DOWN] ? amp_after_up :
	                        ((amp_after_up >= amp_step_q) ? (amp_after_up - amp_step_q) : 8'd0);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and frequency-unit operations.
	always_comb begin
		state_d  = state_q;
		fop      = FOP_HOLD;
		in_stall = 1'b1;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_UP;
				end
			end
			ST_UP: begin
				fop     = freq_press_q[0] ? FOP_UP : FOP_HOLD;
				state_d = ST_DOWN;
			end
			ST_DOWN: begin
				fop     = freq_press_q[1] ? FOP_DOWN : FOP_HOLD;
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				if (!out_valid_q || !out_stall) begin
					fop      = FOP_CLAMP;
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = in_valid && !in_stall;

	// Settings and per-request press flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q        <= RST_AMPLITUDE;
			wave_q       <= '0;
			freq_press_q <= '0;
			changed_q    <= 1'b0;
		end else if (accept) begin
			amp_q        <= amp_after_down;
			wave_q       <= wave_q + 2'(press[BTN_WAVE_NEXT]);
			freq_press_q <= {press[BTN_FREQ_DOWN], press[BTN_FREQ_UP]};
			changed_q    <= |press;
		end
	end

	// Output register: a result waits here while the next request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rsp_q.freq_q8   <= freq_clamped;
			out_rsp_q.amplitude <= amp_q;
			out_rsp_q.waveform  <= wave_q;
			out_rsp_q.changed   <= changed_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	// A new result appears only right after the clamp cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_CLAMP))
		else $error("result appeared without a clamp cycle");

	// An accepted request always starts the multiplier slots next.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_UP)
		else $error("accepted request did not start the sequence");

	// Leaving the clamp cycle always leaves a result in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q == ST_CLAMP) && state_q == ST_IDLE) |-> out_valid_q)
		else $error("sequence finished without a result");

endmodule

// ----- tb/panel_settings_checker.sv -----
// Checker for the debounced button settings panel: follows the request,
// result and configuration ports, predicts each result and compares it.
// Depends on dbsp_pkg for the payload types, register indexes and reset values.
`timescale 1ns / 1ps

module panel_settings_checker #(
	parameter int TIME_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  dbsp_pkg::in_req_t                  in_req,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  dbsp_pkg::out_rsp_t                 out_rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic                               pready,
	input  logic [dbsp_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [dbsp_pkg::CFG_DATA_W-1:0]    pwdata,
	output int                                 error_count,
	output int                                 pending_count
);
	import dbsp_pkg::*;

	localparam logic [31:0] TIME_MASK = 32'hFFFF_FFFF >> (32 - TIME_BITS);

	// Mirror of the configuration registers.
	logic [15:0]            hold_ms;
	logic [7:0]             amp_step;
	logic [16:0]            up_factor;
	logic [15:0]            down_factor;
	logic [31:0]            freq_min;
	logic [31:0]            freq_max;

	// Per-button debounce state and the panel settings.
	logic [NUM_BUTTONS-1:0] settled_level;
	logic [NUM_BUTTONS-1:0] raw_level;
	logic [31:0]            raw_since [NUM_BUTTONS];
	logic [31:0]            freq;
	logic [7:0]             amp;
	logic [1:0]             wave;

	out_rsp_t               expected_settings [$];
	out_rsp_t               want;

	// Tracks one button's raw level and reports an accepted press.
	function automatic logic debounce_press(int b, logic raw, logic [31:0] now);
		logic was;
		if (raw != raw_level[b]) begin
			raw_level[b] = raw;
			raw_since[b] = now;
		end
		if (((now - raw_since[b]) & TIME_MASK) >= {16'd0, hold_ms} &&
				settled_level[b] != raw_level[b]) begin
			was = settled_level[b];
			settled_level[b] = raw_level[b];
			return was && !settled_level[b];
		end
		return 1'b0;
	endfunction

	// Applies one request to the settings and returns the result it should produce.
	function automatic out_rsp_t apply_request(in_req_t r);
		logic [NUM_BUTTONS-1:0] lv;
		logic [NUM_BUTTONS-1:0] pressed;
		logic [63:0]            f;
		logic [31:0]            now;
		out_rsp_t               rsp;
		int                     b;
		now = r.now_ms & TIME_MASK;
		lv[BTN_FREQ_UP]   = r.freq_up_level;
		lv[BTN_FREQ_DOWN] = r.freq_down_level;
		lv[BTN_AMP_UP]    = r.amp_up_level;
		lv[BTN_AMP_DOWN]  = r.amp_down_level;
		lv[BTN_WAVE_NEXT] = r.wave_next_level;
		for (b = 0; b < NUM_BUTTONS; b++)
			pressed[b] = debounce_press(b, lv[b], now);

		// Frequency keeps its full width until the clamp.
		f = {32'd0, freq};
		if (pressed[BTN_FREQ_UP])
			f = (f * {47'd0, up_factor}) >> FRAC_BITS;
		if (pressed[BTN_FREQ_DOWN])
			f = (f * {48'd0, down_factor}) >> FRAC_BITS;
		if (pressed[BTN_AMP_UP])
			amp = (amp <= AMP_MAX - amp_step) ? amp + amp_step : AMP_MAX;
		if (pressed[BTN_AMP_DOWN])
			amp = (amp >= amp_step) ? amp - amp_step : 8'd0;
		if (pressed[BTN_WAVE_NEXT])
			wave = wave + 2'd1;

		// Raise to the minimum first, then lower to the maximum.
		if (f < {32'd0, freq_min})
			f = {32'd0, freq_min};
		if (f > {32'd0, freq_max})
			f = {32'd0, freq_max};
		freq = f[31:0];

		rsp.freq_q8   = freq;
		rsp.amplitude = amp;
		rsp.waveform  = wave;
		rsp.changed   = |pressed;
		return rsp;
	endfunction

	// Reports a field that differs and returns the number of failures it adds.
	function automatic int field_differs(string name, logic [31:0] exp_val,
			logic [31:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, actual %0d", name, exp_val, got_val);
			return 1;
		end
		return 0;
	endfunction

	// Results are checked before the request of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ms       = RST_SETTLE_MS;
			amp_step      = RST_AMP_STEP;
			up_factor     = RST_UP_FACTOR;
			down_factor   = RST_DOWN_FACTOR;
			freq_min      = RST_FREQ_MIN;
			freq_max      = RST_FREQ_MAX;
			settled_level = '1;
			raw_level     = '1;
			for (int b = 0; b < NUM_BUTTONS; b++)
				raw_since[b] = '0;
			freq          = RST_FREQ[31:0];
			amp           = RST_AMPLITUDE;
			wave          = '0;
			error_count   = 0;
			expected_settings.delete();
			pending_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_settings.size() == 0) begin
					$error("result with no request outstanding: freq_q8 %0d", out_rsp.freq_q8);
					error_count++;
				end else begin
					want = expected_settings.pop_front();
					error_count += field_differs("freq_q8", want.freq_q8, out_rsp.freq_q8);
					error_count += field_differs("amplitude", {24'd0, want.amplitude},
						{24'd0, out_rsp.amplitude});
					error_count += field_differs("waveform", {30'd0, want.waveform},
						{30'd0, out_rsp.waveform});
					error_count += field_differs("changed", {31'd0, want.changed},
						{31'd0, out_rsp.changed});
				end
			end

			// Register writes land in the mirror; unknown indexes are dropped.
			if (psel && penable && pwrite && pready) begin
				case (paddr[CFG_ADDR_W-1:2])
					REG_SETTLE_MS:   hold_ms     = pwdata[15:0];
					REG_AMP_STEP:    amp_step    = pwdata[7:0];
					REG_UP_FACTOR:   up_factor   = pwdata[16:0];
					REG_DOWN_FACTOR: down_factor = pwdata[15:0];
					REG_FREQ_MIN:    freq_min    = pwdata;
					REG_FREQ_MAX:    freq_max    = pwdata;
					default: ;
				endcase
			end

			if (in_valid && !in_stall)
				expected_settings.push_back(apply_request(in_req));
			pending_count <= expected_settings.size();
		end
	end

endmodule

// ----- tb/debounced_button_settings_panel_tb.sv -----
// Top of the settings panel testbench: clock, reset, request and register
// stimulus, random output stalls and the final verdict.
// Depends on dbsp_pkg, debounced_button_settings_panel and panel_settings_checker.
`timescale 1ns / 1ps

module debounced_button_settings_panel_tb;
	import dbsp_pkg::*;

	// Indexes that decode to no register.
	localparam logic [2:0] REG_UNUSED_A = 3'd6;
	localparam logic [2:0] REG_UNUSED_B = 3'd7;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_req_t               in_req   = '1;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_rsp_t              out_rsp;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr    = '0;
	logic [CFG_DATA_W-1:0] pwdata   = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	int                    error_count;
	int                    pending_count;

	// Stimulus bookkeeping.
	logic [31:0]           stamp_ms = '0;
	int                    hold_ms  = 25;
	int                    sent_items = 0;
	bit                    gaps_on  = 1'b1;
	bit                    junk_on  = 1'b0;
	int                    stall_left = 0;
	int                    run_left   = 0;

	debounced_button_settings_panel dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rsp   (out_rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	panel_settings_checker settings_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_req        (in_req),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_rsp       (out_rsp),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.error_count   (error_count),
		.pending_count (pending_count)
	);

	always #5 clk = ~clk;

	// Output stalls: short bursts with short runs between them, now and then a
	// long stall or a long stretch with no stall at all.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (run_left != 0) begin
			run_left  <= run_left - 1;
			out_stall <= 1'b0;
		end else begin
			out_stall  <= 1'b0;
			run_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150) :
				$urandom_range(0, 4);
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) :
				$urandom_range(1, 3);
		end
	end

	// One register write: setup cycle, then access cycle until pready.
	task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Writes all six registers; unused upper data bits carry junk when asked.
	task automatic set_panel(logic [31:0] deb, logic [31:0] step, logic [31:0] up,
			logic [31:0] down, logic [31:0] fmin, logic [31:0] fmax);
		logic [31:0] junk;
		junk = junk_on ? $urandom() : 32'd0;
		cfg_write(REG_SETTLE_MS, {junk[31:16], deb[15:0]});
		cfg_write(REG_AMP_STEP, {junk[31:8], step[7:0]});
		cfg_write(REG_UP_FACTOR, {junk[31:17], up[16:0]});
		cfg_write(REG_DOWN_FACTOR, {junk[31:16], down[15:0]});
		cfg_write(REG_FREQ_MIN, fmin);
		cfg_write(REG_FREQ_MAX, fmax);
		hold_ms = deb[15:0];
	endtask

	// Lets every outstanding result drain so the block is idle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Sends one request dt milliseconds after the previous one. Levels are in
	// struct order: freq up in bit 4 down to wave next in bit 0.
	task automatic send_levels(logic [4:0] lv, logic [31:0] dt);
		int gap;
		int r;
		stamp_ms = stamp_ms + dt;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_req   <= {stamp_ms, lv};
		do @(posedge clk); while (in_stall);
		sent_items++;
	endtask

	// Press and release of the buttons in mask, each level held long enough,
	// optionally with contact bounce around both edges.
	task automatic press_cycle(logic [4:0] mask, bit bouncy);
		if (bouncy)
			repeat ($urandom_range(0, 3))
				send_levels(5'($urandom_range(0, 31)), $urandom_range(0, hold_ms / 2));
		send_levels(~mask, $urandom_range(0, 2));
		send_levels(~mask, hold_ms + $urandom_range(0, 3));
		if (bouncy)
			repeat ($urandom_range(0, 2))
				send_levels(~mask | 5'($urandom_range(0, 31)),
					$urandom_range(0, hold_ms / 2));
		send_levels(5'h1F, $urandom_range(0, 2));
		send_levels(5'h1F, hold_ms + $urandom_range(0, 3));
	endtask

	// Mostly press sequences with random content, the rest raw noise.
	task automatic random_run(int count);
		int target;
		int r;
		target = sent_items + count;
		while (sent_items < target) begin
			gaps_on = ($urandom_range(0, 4) != 0);
			r = $urandom_range(0, 99);
			if (r < 45)
				press_cycle(5'b1 << $urandom_range(0, 4), 1'b1);
			else if (r < 70)
				press_cycle(5'($urandom_range(0, 31)), 1'b1);
			else
				repeat ($urandom_range(1, 4))
					send_levels(5'($urandom_range(0, 31)), $urandom_range(0, 2 * hold_ms + 2));
		end
	endtask

	initial begin
		int phase;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (phase = 0; phase < 7; phase++) begin
			drain();
			case (phase)
				0: begin
					// Reset settings: each button alone, then all five together.
					send_levels(5'h1F, 32'd0);
					for (int b = 0; b < NUM_BUTTONS; b++)
						press_cycle(5'b1 << b, 1'b0);
					press_cycle(5'h1F, 1'b0);
				end
				1: begin
					// Zero debounce, largest factors and step, frequency near the top.
					set_panel(32'd0, 32'd255, 32'd131071, 32'd65535,
						32'hF000_0000, 32'hFFFF_FFFF);
				end
				2: begin
					// Unity up factor, zero down factor, a step of one; a down press drops to zero.
					set_panel(32'd1, 32'd1, 32'd65536, 32'd0, 32'd0, 32'd1000000);
				end
				3: begin
					// Longest debounce across the time stamp wrap.
					set_panel(32'd65535, 32'd7, 32'd100000, 32'd30000,
						32'd5000, 32'hFFFF_FFFF);
					stamp_ms = 32'hFFFF_FFFE;
					send_levels(5'h1F, 32'd1);
				end
				4: begin
					// Minimum above maximum and a zero amplitude step.
					set_panel(32'd5, 32'd0, 32'd72090, 32'd58982,
						32'hFFFF_FFFF, 32'd500000);
				end
				default: begin
					// Random settings, junk in unused data bits, unknown indexes.
					junk_on = 1'b1;
					cfg_write(REG_UNUSED_A, $urandom());
					cfg_write(REG_UNUSED_B, $urandom());
					set_panel($urandom_range(0, 40), $urandom_range(0, 255),
						$urandom_range(0, 131071), $urandom_range(0, 65535),
						$urandom_range(0, 2000000), $urandom());
					stamp_ms = $urandom();
				end
			endcase
			random_run(150);
		end

		drain();
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
